// ===== src/i2c_register_access_master_defines.svh =====
// assertion macros for the i2c register access master
// no dependencies; taken in by the modules that carry assertions
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define I2CRAM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// condition must never be seen outside reset
`define I2CRAM_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);
`else
`define I2CRAM_ASSERT(label, clk, rst_n, prop, msg)
`define I2CRAM_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/i2cram_pkg.sv =====
// shared types and constants of the i2c register access master
// no dependencies; imported by all modules of the block
`timescale 1ns / 1ps
`default_nettype none

package i2cram_pkg;

	// request kinds
	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_WRITE   = 2'd1;
	localparam logic [1:0] REQ_READ    = 2'd2;
	localparam logic [1:0] REQ_RECOVER = 2'd3;

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_TICKS_PER_US   = 1'b1;

	localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd104;
	localparam logic [7:0] TICKS_PER_US_RESET   = 8'd1;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic [7:0] read_count;
		logic       sda_level;
	} item_t;

	typedef struct packed {
		logic       scl_release;
		logic       sda_release;
		logic       busy_res;
		logic       byte_valid;
		logic [7:0] read_byte;
		logic       last_byte;
		logic       done_res;
		logic       nack_seen;
	} res_t;

endpackage

`default_nettype wire

// ===== src/i2cram_front.sv =====
// request front end: accepts requests and classifies them for the queue
// depends on i2cram_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cram_front (
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        req_type,
	input  logic [7:0]        reg_addr,
	input  logic [7:0]        write_data,
	input  logic [7:0]        read_count,
	input  logic              sda_level,
	input  logic              q_full,
	output logic              q_push,
	output i2cram_pkg::item_t q_wdata
);
	import i2cram_pkg::*;

	logic is_cmd;

	assign item_stall = q_full;
	assign q_push     = item_valid && !q_full;
	assign is_cmd     = (req_type != REQ_TICK);

	// plain ticks carry only the line sample; an empty burst reads one byte
	always_comb begin
		q_wdata.req_type   = req_type;
		q_wdata.sda_level  = sda_level;
		q_wdata.reg_addr   = is_cmd ? reg_addr : 8'd0;
		q_wdata.write_data = is_cmd ? write_data : 8'd0;
		if (!is_cmd) begin
			q_wdata.read_count = 8'd0;
		end else if (read_count == 8'd0) begin
			q_wdata.read_count = 8'd1;
		end else begin
			q_wdata.read_count = read_count;
		end
	end

endmodule

`default_nettype wire

// ===== src/i2cram_queue.sv =====
// short request queue between front end and bus sequencer
// depends on i2cram_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cram_queue #(
	parameter int DEPTH = i2cram_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cram_pkg::item_t wdata,
	output logic              full,
	output logic              valid,
	input  logic              pop,
	output i2cram_pkg::item_t rdata
);
	import i2cram_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdata   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/i2cram_back.sv =====
// bus sequencer: one tick per request, drives the open-drain lines
// depends on i2cram_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_register_access_master_defines.svh"

module i2cram_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [6:0]        dev_addr,
	input  logic [7:0]        ticks_per_us,
	input  logic              q_valid,
	input  i2cram_pkg::item_t q_item,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_stall,
	output i2cram_pkg::res_t  res
);
	import i2cram_pkg::*;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_W_START   = 4'd1;
	localparam logic [3:0] PH_W_ADDR    = 4'd2;
	localparam logic [3:0] PH_W_REG     = 4'd3;
	localparam logic [3:0] PH_W_VAL     = 4'd4;
	localparam logic [3:0] PH_R_START   = 4'd5;
	localparam logic [3:0] PH_R_ADDR    = 4'd6;
	localparam logic [3:0] PH_R_REG     = 4'd7;
	localparam logic [3:0] PH_R_STOP    = 4'd8;
	localparam logic [3:0] PH_R_RESTART = 4'd9;
	localparam logic [3:0] PH_R_ADDRR   = 4'd10;
	localparam logic [3:0] PH_R_DATA    = 4'd11;
	localparam logic [3:0] PH_RC_PULSE  = 4'd12;
	localparam logic [3:0] PH_FIN_STOP  = 4'd13;

	localparam logic [2:0] K_START = 3'd0;
	localparam logic [2:0] K_WRITE = 3'd1;
	localparam logic [2:0] K_READ  = 3'd2;
	localparam logic [2:0] K_STOP  = 3'd3;
	localparam logic [2:0] K_PULSE = 3'd4;

	function automatic logic [2:0] kind_of(input logic [3:0] ph);
		logic [2:0] k;
		case (ph)
			PH_W_START, PH_R_START, PH_R_RESTART: k = K_START;
			PH_R_DATA:                            k = K_READ;
			PH_R_STOP, PH_FIN_STOP:               k = K_STOP;
			PH_RC_PULSE:                          k = K_PULSE;
			default:                              k = K_WRITE;
		endcase
		return k;
	endfunction

	logic [3:0] phase_q, nphase;
	logic [1:0] sub_q, nsub;
	logic [3:0] bitc_q, nbitc;
	logic [7:0] bytes_q, nbytes;
	logic [9:0] delay_q, ndelay;
	logic [7:0] shift_q, nshift;
	logic [7:0] sreg_q, nsreg;
	logic [7:0] sval_q, nsval;
	logic       nack_q, nnack;
	logic       scl_q, nscl;
	logic       sda_q, nsda;

	logic       res_valid_q;
	res_t       res_q;
	res_t       step_res;
	res_t       res_next;
	logic       fire;

	logic       idle;
	logic       accept_cmd;
	logic       ld;
	logic       adv;
	logic [2:0] kind;
	logic [2:0] lkind;
	logic [1:0] units;
	logic [7:0] tpu;
	logic [9:0] step_len;
	logic [7:0] rshift;

	assign fire      = q_valid && (!res_valid_q || !res_stall);
	assign q_pop     = fire;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign idle       = (phase_q == PH_IDLE);
	assign accept_cmd = idle && (q_item.req_type != REQ_TICK);
	assign kind       = kind_of(phase_q);
	assign tpu        = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
	assign rshift     = {shift_q[6:0], q_item.sda_level};

	// next state for one tick
	always_comb begin
		nphase   = phase_q;
		nsub     = sub_q;
		nbitc    = bitc_q;
		nbytes   = bytes_q;
		ndelay   = delay_q;
		nshift   = shift_q;
		nsreg    = sreg_q;
		nsval    = sval_q;
		nnack    = nack_q;
		ld       = 1'b0;
		adv      = 1'b0;
		step_res = '0;

		if (accept_cmd) begin
			nnack  = 1'b0;
			nsreg  = q_item.reg_addr;
			nsval  = q_item.write_data;
			nbytes = q_item.read_count;
			nsub   = 2'd0;
			nbitc  = 4'd0;
			nshift = 8'd0;
			ld     = 1'b1;
			case (q_item.req_type)
				REQ_WRITE: nphase = PH_W_START;
				REQ_READ:  nphase = PH_R_START;
				default:   nphase = PH_RC_PULSE;
			endcase
		end else if (!idle) begin
			if (delay_q != 10'd0) begin
				ndelay = delay_q - 10'd1;
			end
			if (delay_q <= 10'd1) begin
				case (kind)
					K_START: begin
						if (sub_q < 2'd2) begin
							nsub = sub_q + 2'd1;
							ld   = 1'b1;
						end else begin
							adv = 1'b1;
						end
					end
					K_WRITE: begin
						if (sub_q == 2'd1 && bitc_q == 4'd8 && q_item.sda_level) begin
							nnack = 1'b1;
						end
						if (sub_q < 2'd2) begin
							nsub = sub_q + 2'd1;
							ld   = 1'b1;
						end else begin
							nshift = {shift_q[6:0], 1'b0};
							nbitc  = bitc_q + 4'd1;
							if (bitc_q >= 4'd8) begin
								adv = 1'b1;
							end else begin
								nsub = 2'd0;
								ld   = 1'b1;
							end
						end
					end
					K_READ: begin
						if (sub_q == 2'd1 && bitc_q < 4'd8) begin
							nshift = rshift;
							if (bitc_q == 4'd7) begin
								step_res.byte_valid = 1'b1;
								step_res.read_byte  = rshift;
								step_res.last_byte  = (bytes_q == 8'd1);
							end
						end
						if (sub_q < 2'd2) begin
							nsub = sub_q + 2'd1;
							ld   = 1'b1;
						end else begin
							nbitc = bitc_q + 4'd1;
							if (bitc_q >= 4'd8) begin
								nbytes = bytes_q - 8'd1;
								if (bytes_q == 8'd1) begin
									adv = 1'b1;
								end else begin
									nbitc  = 4'd0;
									nshift = 8'd0;
									nsub   = 2'd0;
									ld     = 1'b1;
								end
							end else begin
								nsub = 2'd0;
								ld   = 1'b1;
							end
						end
					end
					K_STOP: begin
						if (sub_q < 2'd2) begin
							nsub = sub_q + 2'd1;
							ld   = 1'b1;
						end else if (phase_q == PH_FIN_STOP) begin
							step_res.done_res  = 1'b1;
							step_res.nack_seen = nack_q;
							nphase = PH_IDLE;
							nsub   = 2'd0;
							nbitc  = 4'd0;
							ndelay = 10'd0;
						end else begin
							adv = 1'b1;
						end
					end
					default: begin
						if (sub_q == 2'd0) begin
							nsub = 2'd1;
							ld   = 1'b1;
						end else begin
							nbitc = bitc_q + 4'd1;
							if (bitc_q >= 4'd8) begin
								adv = 1'b1;
							end else begin
								nsub = 2'd0;
								ld   = 1'b1;
							end
						end
					end
				endcase
			end
		end

		// move on to the next bus element and load its shift byte
		if (adv) begin
			if (phase_q inside {PH_W_VAL, PH_R_DATA, PH_RC_PULSE}) begin
				nphase = PH_FIN_STOP;
			end else begin
				nphase = phase_q + 4'd1;
			end
			nsub  = 2'd0;
			nbitc = 4'd0;
			ld    = 1'b1;
			case (nphase)
				PH_W_ADDR, PH_R_ADDR: nshift = {dev_addr, 1'b0};
				PH_R_ADDRR:           nshift = {dev_addr, 1'b1};
				PH_W_REG, PH_R_REG:   nshift = sreg_q;
				PH_W_VAL:             nshift = sval_q;
				default:              nshift = 8'd0;
			endcase
		end
	end

	// line levels and length of the step being loaded
	always_comb begin
		lkind = kind_of(nphase);
		units = 2'd3;
		nscl  = scl_q;
		nsda  = sda_q;
		if (ld) begin
			case (lkind)
				K_START: begin
					if (nsub == 2'd0) begin
						nscl = 1'b1;
						nsda = 1'b1;
					end else if (nsub == 2'd1) begin
						nsda = 1'b0;
					end else begin
						nscl = 1'b0;
					end
				end
				K_WRITE, K_READ: begin
					if (nsub == 2'd0) begin
						units = 2'd1;
						if (nbitc < 4'd8) begin
							nsda = (lkind == K_WRITE) ? nshift[7] : 1'b1;
						end else begin
							nsda = (lkind == K_WRITE) ? 1'b1 : !(nbytes > 8'd1);
						end
					end else if (nsub == 2'd1) begin
						nscl = 1'b1;
					end else begin
						units = 2'd2;
						nscl  = 1'b0;
					end
				end
				K_STOP: begin
					if (nsub == 2'd0) begin
						units = 2'd1;
						nsda  = 1'b0;
					end else if (nsub == 2'd1) begin
						nscl = 1'b1;
					end else begin
						nsda = 1'b1;
					end
				end
				default: begin
					if (nsub == 2'd0) begin
						nscl = 1'b0;
						nsda = 1'b1;
					end else begin
						nscl = 1'b1;
					end
				end
			endcase
		end
		case (units)
			2'd1:    step_len = {2'b00, tpu};
			2'd2:    step_len = {1'b0, tpu, 1'b0};
			default: step_len = {2'b00, tpu} + {1'b0, tpu, 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sub_q       <= 2'd0;
			bitc_q      <= 4'd0;
			bytes_q     <= 8'd0;
			delay_q     <= 10'd0;
			shift_q     <= 8'd0;
			sreg_q      <= 8'd0;
			sval_q      <= 8'd0;
			nack_q      <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= nphase;
				sub_q       <= nsub;
				bitc_q      <= nbitc;
				bytes_q     <= nbytes;
				shift_q     <= nshift;
				sreg_q      <= nsreg;
				sval_q      <= nsval;
				nack_q      <= nnack;
				scl_q       <= nscl;
				sda_q       <= nsda;
				// the accepting tick also counts down once
				if (ld) begin
					delay_q <= accept_cmd ? step_len - 10'd1 : step_len;
				end else begin
					delay_q <= ndelay;
				end
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result shows the lines as driven during this tick
	always_comb begin
		res_next             = step_res;
		res_next.scl_release = accept_cmd ? nscl : scl_q;
		res_next.sda_release = accept_cmd ? nsda : sda_q;
		res_next.busy_res    = !idle || accept_cmd;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_next;
		end
	end

	`I2CRAM_ASSERT(a_delay_live, clk, arst_n, (phase_q != PH_IDLE) |-> (delay_q != 10'd0), "bus step with empty delay")
	`I2CRAM_ASSERT(a_idle_clean, clk, arst_n, (phase_q == PH_IDLE) |-> (sub_q == 2'd0 && bitc_q == 4'd0), "idle with stale position")
	`I2CRAM_NEVER(a_byte_and_done, clk, arst_n, res_valid_q && res_q.byte_valid && res_q.done_res, "read byte on the stop tick")
	`I2CRAM_ASSERT(a_cmd_starts, clk, arst_n, (fire && accept_cmd) |=> (phase_q != PH_IDLE), "command not started")

endmodule

`default_nettype wire

// ===== src/i2c_register_access_master.sv =====
// i2c register access master top level: config registers, front end, queue, sequencer
// depends on i2cram_pkg, i2cram_front, i2cram_queue, i2cram_back
//
// usage
//  - each request on the item channel (item_valid / item_stall) is one bus tick: the sampled
//    sda level plus an optional command (register write, burst read, bus recovery)
//  - a command is taken only when the sequencer is idle; otherwise it counts as a plain tick
//  - every request gives exactly one result on the res channel (res_valid / res_stall)
//    with the scl/sda release levels for that tick and the busy, byte and done flags
//  - the result of a request is registered and offered once the sequencer pops it
//  - throughput: one request per cycle while res_stall is low or no result is offered
//  - bit timing: each bus step lasts 1, 2 or 3 units of ticks_per_microsecond requests
//  - the queue of QDEPTH entries decouples the front end; item_stall rises when it is full
//  - when res_stall is high while a result is offered, the result register holds and the
//    sequencer waits; requests keep entering until the queue fills
//  - reset: sequencer idle, both lines released, queue empty, device_address 104 and
//    ticks_per_microsecond 1
//  - apb: device_address at byte 0x0, ticks_per_microsecond at 0x4, pready always high;
//    write only while no request is outstanding
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master #(
	parameter int QDEPTH = i2cram_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [i2cram_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// request channel
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     req_type,
	input  logic [7:0]                     reg_addr,
	input  logic [7:0]                     write_data,
	input  logic [7:0]                     read_count,
	input  logic                           sda_level,
	// result channel
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic                           scl_release,
	output logic                           sda_release,
	output logic                           busy_res,
	output logic                           byte_valid,
	output logic [7:0]                     read_byte,
	output logic                           last_byte,
	output logic                           done_res,
	output logic                           nack_seen
);
	import i2cram_pkg::*;

	logic [6:0] dev_addr_q;
	logic [7:0] tpu_q;
	logic       reg_idx;
	logic       cfg_wr;

	logic       q_push;
	logic       q_full;
	logic       q_valid;
	logic       q_pop;
	item_t      q_wdata;
	item_t      q_rdata;
	res_t       res;

	// register select is the word index of the byte address
	assign reg_idx = paddr[PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RESET;
			tpu_q      <= TICKS_PER_US_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_DEVICE_ADDRESS: dev_addr_q <= pwdata[6:0];
				REG_TICKS_PER_US:   tpu_q      <= pwdata[7:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEVICE_ADDRESS: prdata = {25'd0, dev_addr_q};
			REG_TICKS_PER_US:   prdata = {24'd0, tpu_q};
			default:            prdata = 32'd0;
		endcase
	end

	// front end classifies requests into the queue
	i2cram_front u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.req_type   (req_type),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.read_count (read_count),
		.sda_level  (sda_level),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_wdata    (q_wdata)
	);

	i2cram_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (q_pop),
		.rdata  (q_rdata)
	);

	// bus sequencer, one tick per popped request
	i2cram_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.dev_addr     (dev_addr_q),
		.ticks_per_us (tpu_q),
		.q_valid      (q_valid),
		.q_item       (q_rdata),
		.q_pop        (q_pop),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.res          (res)
	);

	assign scl_release = res.scl_release;
	assign sda_release = res.sda_release;
	assign busy_res    = res.busy_res;
	assign byte_valid  = res.byte_valid;
	assign read_byte   = res.read_byte;
	assign last_byte   = res.last_byte;
	assign done_res    = res.done_res;
	assign nack_seen   = res.nack_seen;

endmodule

`default_nettype wire
